// ===== design/rgba_to_ycbcr_alpha_blend_assert.svh =====
// Assertion macros used by the RTL.
`ifndef RGBA_TO_YCBCR_ALPHA_BLEND_ASSERT_SVH
`define RGBA_TO_YCBCR_ALPHA_BLEND_ASSERT_SVH

// Antecedent holds on a clock edge -> consequent holds on the same edge.
`define RTYAB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds on a clock edge -> consequent holds on the next edge.
`define RTYAB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rtyab_pkg.sv =====
`default_nettype none

package rtyab_pkg;

  // BT.601 studio-range coefficients, value * 65536 rounded
  localparam logic [15:0] COEF_YR  = 16'd16843;
  localparam logic [15:0] COEF_YG  = 16'd33030;
  localparam logic [15:0] COEF_YB  = 16'd6423;
  localparam logic [15:0] COEF_CBR = 16'd9699;
  localparam logic [15:0] COEF_CBG = 16'd19071;
  localparam logic [15:0] COEF_CBB = 16'd28770;
  localparam logic [15:0] COEF_CRR = 16'd28770;
  localparam logic [15:0] COEF_CRG = 16'd24117;
  localparam logic [15:0] COEF_CRB = 16'd4653;
  localparam logic [23:0] OFS_Y    = 24'(16) << 16;
  localparam logic [23:0] OFS_C    = 24'(128) << 16;
  localparam logic [7:0]  FULL     = 8'd255;

  localparam int unsigned CSC_LATENCY = 2;
  localparam int unsigned LATENCY     = 4;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
    logic       chroma_site;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] cb_out;
    logic [7:0] cr_out;
    logic       luma_write;
    logic       chroma_write;
  } result_t;

  // converted overlay color with the beat's background fields alongside
  typedef struct packed {
    logic       valid;
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
    logic [7:0] alpha;
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
    logic       chroma_site;
  } csc_t;

endpackage

`default_nettype wire

// ===== design/rtyab_csc.sv =====
`default_nettype none

// Two-stage RGB to YCbCr conversion: products, then sums.
module rtyab_csc import rtyab_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   valid,
  input  wire pixel_t pixel,
  output csc_t        ycc
);

  logic        v1;
  pixel_t      px1;
  logic [23:0] p_yr, p_yg, p_yb;
  logic [23:0] p_cbr, p_cbg, p_cbb;
  logic [23:0] p_crr, p_crg, p_crb;

  logic [23:0] y_sum, cb_sum, cr_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= valid;
    end
  end

  always_ff @(posedge clk) begin
    px1   <= pixel;
    p_yr  <= {8'd0, COEF_YR}  * {16'd0, pixel.red};
    p_yg  <= {8'd0, COEF_YG}  * {16'd0, pixel.green};
    p_yb  <= {8'd0, COEF_YB}  * {16'd0, pixel.blue};
    p_cbr <= {8'd0, COEF_CBR} * {16'd0, pixel.red};
    p_cbg <= {8'd0, COEF_CBG} * {16'd0, pixel.green};
    p_cbb <= {8'd0, COEF_CBB} * {16'd0, pixel.blue};
    p_crr <= {8'd0, COEF_CRR} * {16'd0, pixel.red};
    p_crg <= {8'd0, COEF_CRG} * {16'd0, pixel.green};
    p_crb <= {8'd0, COEF_CRB} * {16'd0, pixel.blue};
  end

  // true sums stay in 0..2^24-1, so modular subtraction is exact
  assign y_sum  = p_yr + p_yg + p_yb + OFS_Y;
  assign cb_sum = p_cbb + OFS_C - p_cbr - p_cbg;
  assign cr_sum = p_crr + OFS_C - p_crg - p_crb;

  always_ff @(posedge clk) begin
    if (rst) begin
      ycc.valid <= 1'b0;
    end else begin
      ycc.valid <= v1;
    end
    ycc.y           <= y_sum[23:16];
    ycc.cb          <= cb_sum[23:16];
    ycc.cr          <= cr_sum[23:16];
    ycc.alpha       <= px1.alpha;
    ycc.luma_in     <= px1.luma_in;
    ycc.cb_in       <= px1.cb_in;
    ycc.cr_in       <= px1.cr_in;
    ycc.chroma_site <= px1.chroma_site;
  end

endmodule

`default_nettype wire

// ===== design/rgba_to_ycbcr_alpha_blend.sv =====
// Throughput: one pixel per cycle; busy is always low, the four-stage
// pipeline (2 conversion stages, blend products, divide and add) never stalls.
// Reset: synchronous, clears the pipeline valid bits; no result follows
// a beat that was in flight when reset was applied.
`default_nettype none

module rgba_to_ycbcr_alpha_blend import rtyab_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire pixel_t pixel,
  output logic        done,
  output result_t     result
);

  `include "rgba_to_ycbcr_alpha_blend_assert.svh"

  logic accept;
  csc_t ycc;

  // stage 3: blend products
  logic        v3;
  logic [15:0] fy, fcb, fcr;
  logic [15:0] by, bcb, bcr;
  logic [7:0]  bg_y, bg_cb, bg_cr;
  logic        a_nz, site3;

  logic [7:0]  inv_a;
  logic [7:0]  blend_y, blend_cb, blend_cr;

  // exact floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + (x >> 8) + 16'd1;
    return t[15:8];
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rtyab_csc u_csc (
    .clk   (clk),
    .rst   (rst),
    .valid (accept),
    .pixel (pixel),
    .ycc   (ycc)
  );

  assign inv_a = FULL - ycc.alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= ycc.valid;
    end
  end

  always_ff @(posedge clk) begin
    fy    <= {8'd0, ycc.y}  * {8'd0, ycc.alpha};
    fcb   <= {8'd0, ycc.cb} * {8'd0, ycc.alpha};
    fcr   <= {8'd0, ycc.cr} * {8'd0, ycc.alpha};
    by    <= {8'd0, ycc.luma_in} * {8'd0, inv_a};
    bcb   <= {8'd0, ycc.cb_in}   * {8'd0, inv_a};
    bcr   <= {8'd0, ycc.cr_in}   * {8'd0, inv_a};
    bg_y  <= ycc.luma_in;
    bg_cb <= ycc.cb_in;
    bg_cr <= ycc.cr_in;
    a_nz  <= (ycc.alpha != 8'd0);
    site3 <= ycc.chroma_site;
  end

  // quotient sum never exceeds 255
  assign blend_y  = div255(fy)  + div255(by);
  assign blend_cb = div255(fcb) + div255(bcb);
  assign blend_cr = div255(fcr) + div255(bcr);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    result.luma_out     <= a_nz ? blend_y : bg_y;
    result.cb_out       <= (a_nz && site3) ? blend_cb : bg_cb;
    result.cr_out       <= (a_nz && site3) ? blend_cr : bg_cr;
    result.luma_write   <= a_nz;
    result.chroma_write <= a_nz && site3;
  end

  // hist_ok: rst was low in every cycle recorded in rst_hist
  logic [3:0] rst_hist;
  logic       hist_ok;

  always_ff @(posedge clk) begin
    rst_hist <= {rst_hist[2:0], rst};
  end

  assign hist_ok = !(|rst_hist);

  `RTYAB_ASSERT_IMPL(a_done_latency, clk, rst, hist_ok, done == $past(accept, 4), "done does not follow start by the pipeline latency")
  `RTYAB_ASSERT_IMPL(a_chroma_needs_luma, clk, rst, done && !result.luma_write, !result.chroma_write, "chroma write without luma write")
  `RTYAB_ASSERT_IMPL(a_alpha_zero_pass, clk, rst, hist_ok && done && !result.luma_write, result.luma_out == $past(pixel.luma_in, 4), "transparent pixel altered the background luma")
  `RTYAB_ASSERT_NEXT(a_no_stall, clk, rst, 1'b1, !busy, "busy raised")

endmodule

`default_nettype wire

// ===== tb/rgba_to_ycbcr_alpha_blend_test.sv =====
`default_nettype none

module rgba_to_ycbcr_alpha_blend_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rtyab_pkg::*;

  // BT.601 studio-range weights, Q16
  localparam int unsigned W_YR  = 16843;
  localparam int unsigned W_YG  = 33030;
  localparam int unsigned W_YB  = 6423;
  localparam int unsigned W_CBR = 9699;
  localparam int unsigned W_CBG = 19071;
  localparam int unsigned W_CBB = 28770;
  localparam int unsigned W_CRR = 28770;
  localparam int unsigned W_CRG = 24117;
  localparam int unsigned W_CRB = 4653;
  localparam int unsigned LUMA_OFFSET   = 16 << 16;
  localparam int unsigned CHROMA_OFFSET = 128 << 16;
  localparam int unsigned OPAQUE        = 255;

  localparam int RANDOM_BEATS  = 400;
  localparam int CALM_TAIL     = 60;
  localparam int STALL_LIMIT   = 500;

  typedef struct {
    pixel_t  px;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  pixel_t  pixel = '0;
  logic    busy;
  logic    done;
  result_t result;

  result_t   beat_want = '0;
  result_t   blend_due[$];
  stim_row_t rows[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;

  rgba_to_ycbcr_alpha_blend i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  function automatic pixel_t mk_px(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                   logic [7:0] a, logic [7:0] y, logic [7:0] cb,
                                   logic [7:0] cr, logic site);
    pixel_t p;
    p.blue = b;
    p.green = g;
    p.red = r;
    p.alpha = a;
    p.luma_in = y;
    p.cb_in = cb;
    p.cr_in = cr;
    p.chroma_site = site;
    return p;
  endfunction

  function automatic result_t mk_res(logic [7:0] y, logic [7:0] cb, logic [7:0] cr,
                                     logic lw, logic cw);
    result_t r;
    r.luma_out = y;
    r.cb_out = cb;
    r.cr_out = cr;
    r.luma_write = lw;
    r.chroma_write = cw;
    return r;
  endfunction

  // both divisions truncate separately
  function automatic logic [7:0] mix(int unsigned v, int unsigned a, int unsigned bg);
    return 8'((v * a) / OPAQUE + ((OPAQUE - a) * bg) / OPAQUE);
  endfunction

  function automatic result_t blend_pixel(pixel_t p);
    int unsigned y;
    int unsigned cb;
    int unsigned cr;
    result_t     r;
    y  = (W_YR * p.red + W_YG * p.green + W_YB * p.blue + LUMA_OFFSET) >> 16;
    // sums stay positive for any 8-bit color, so add before subtracting
    cb = (W_CBB * p.blue + CHROMA_OFFSET - W_CBR * p.red - W_CBG * p.green) >> 16;
    cr = (W_CRR * p.red + CHROMA_OFFSET - W_CRG * p.green - W_CRB * p.blue) >> 16;
    r.luma_write   = (p.alpha != 8'd0);
    r.chroma_write = r.luma_write & p.chroma_site;
    r.luma_out = r.luma_write ? mix(y & 8'hff, p.alpha, p.luma_in) : p.luma_in;
    r.cb_out   = r.chroma_write ? mix(cb & 8'hff, p.alpha, p.cb_in) : p.cb_in;
    r.cr_out   = r.chroma_write ? mix(cr & 8'hff, p.alpha, p.cr_in) : p.cr_in;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    return mk_px(pick_byte(), pick_byte(), pick_byte(), pick_alpha(),
                 pick_byte(), pick_byte(), pick_byte(), 1'($urandom));
  endfunction

  function automatic bit check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(pixel_t p, result_t w);
    start <= 1'b1;
    pixel <= p;
    beat_want <= w;
    do @(posedge clk); while (busy);
  endtask

  // junk on the bus while start is low must be ignored
  task automatic idle_burst(int cycles);
    start <= 1'b0;
    pixel <= random_pixel();
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t w;
    bit      ok;
    if (!rst) begin
      if (done) begin
        if (blend_due.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          w = blend_due.pop_front();
          ok = check_field("luma_out", w.luma_out, result.luma_out);
          ok = check_field("cb_out", w.cb_out, result.cb_out) && ok;
          ok = check_field("cr_out", w.cr_out, result.cr_out) && ok;
          ok = check_field("luma_write", w.luma_write, result.luma_write) && ok;
          ok = check_field("chroma_write", w.chroma_write, result.chroma_write) && ok;
          if (!ok) mismatches++;
        end
      end
      if (start && !busy) blend_due.push_back(beat_want);

      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    bit      calm;
    pixel_t  p;

    // transparent: pure pass-through, no writes
    rows.push_back('{mk_px(255, 255, 255, 0, 255, 255, 255, 1), 1'b1,
                     mk_res(255, 255, 255, 0, 0)});
    rows.push_back('{mk_px(0, 0, 0, 0, 0, 0, 0, 1), 1'b1, mk_res(0, 0, 0, 0, 0)});
    // opaque black and white land on the studio-range limits
    rows.push_back('{mk_px(0, 0, 0, 255, 200, 30, 220, 1), 1'b1,
                     mk_res(16, 128, 128, 1, 1)});
    rows.push_back('{mk_px(255, 255, 255, 255, 0, 0, 0, 1), 1'b1,
                     mk_res(235, 128, 128, 1, 1)});
    // not a chroma site: chroma passes through
    rows.push_back('{mk_px(255, 255, 255, 255, 17, 8'h5a, 8'ha5, 0), 1'b1,
                     mk_res(235, 8'h5a, 8'ha5, 1, 0)});
    // primaries and secondaries, opaque
    rows.push_back('{mk_px(0, 0, 255, 255, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk_px(0, 255, 0, 255, 255, 255, 255, 1), 1'b0, '0});
    rows.push_back('{mk_px(255, 0, 0, 255, 0, 255, 0, 1), 1'b0, '0});
    rows.push_back('{mk_px(0, 255, 255, 255, 128, 128, 128, 1), 1'b0, '0});
    rows.push_back('{mk_px(255, 255, 0, 255, 128, 128, 128, 1), 1'b0, '0});
    rows.push_back('{mk_px(255, 0, 255, 255, 128, 128, 128, 1), 1'b0, '0});
    // partial alpha at the edges and middle, some off chroma sites, and one transparent beat
    rows.push_back('{mk_px(255, 255, 255, 1, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk_px(0, 0, 255, 254, 255, 255, 255, 1), 1'b0, '0});
    rows.push_back('{mk_px(0, 0, 0, 1, 255, 255, 255, 1), 1'b0, '0});
    rows.push_back('{mk_px(255, 0, 0, 128, 0, 255, 0, 1), 1'b0, '0});
    rows.push_back('{mk_px(8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 1), 1'b0, '0});
    rows.push_back('{mk_px(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 0), 1'b0, '0});
    rows.push_back('{mk_px(255, 0, 0, 128, 0, 255, 255, 0), 1'b0, '0});
    rows.push_back('{mk_px(255, 255, 255, 1, 255, 0, 255, 0), 1'b0, '0});
    rows.push_back('{mk_px(0, 0, 0, 0, 77, 99, 11, 0), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_beat(rows[i].px, rows[i].typed ? rows[i].want : blend_pixel(rows[i].px));
      if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 13));
    end

    calm = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      p = random_pixel();
      send_beat(p, blend_pixel(p));
      if (n < RANDOM_BEATS - CALM_TAIL && !calm && $urandom_range(0, 2) == 0)
        idle_burst($urandom_range(1, 13));
    end
    start <= 1'b0;

    while (blend_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
